// ===== src/csu_pkg.sv =====
package csu_pkg;

   // Accumulator and arithmetic widths
   localparam int ACC_W   = 48;   // dot and norm sums
   localparam int LIMB_W  = 32;   // multiplier operand width
   localparam int PROD_W  = 64;   // multiplier product width
   localparam int DEN_W   = 96;   // norm_a * norm_b
   localparam int WIDE_W  = 128;  // comparison width
   localparam int SCORE_W = 16;
   localparam int MAG_W   = 16;   // score magnitude, 0 .. 32768
   localparam int BIT_W   = 4;    // index of the magnitude bit under test
   localparam int STEP_W  = 2;    // partial product index

   localparam logic [SCORE_W-1:0] SCORE_MAX = 16'h7FFF;
   localparam logic [SCORE_W-1:0] SCORE_MIN = 16'h8000;
   localparam logic [BIT_W-1:0]   TOP_BIT   = 4'd15;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_CHECK,
      ST_DEN_MUL,
      ST_DEN_ADD,
      ST_DEN_STORE,
      ST_DSQ_MUL,
      ST_DSQ_ADD,
      ST_DSQ_STORE,
      ST_ODD_MUL,
      ST_ODD_STORE,
      ST_LHS_MUL,
      ST_LHS_ADD,
      ST_COMPARE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_DEN,   // norm_a limb * norm_b limb
      MUL_DSQ,   // |dot| limb * |dot| limb
      MUL_ODD,   // (2m-1) squared
      MUL_LHS    // denominator limb * (2m-1)^2
   } mul_sel_type;

   typedef struct packed {
      logic              take_item;
      logic              clear_sums;
      logic              load_mag;
      logic              clear_acc;
      logic              acc_add;
      logic [1:0]        shift;
      mul_sel_type       mul_sel;
      logic [STEP_W-1:0] step;
      logic              load_den;
      logic              load_rhs;
      logic              load_k;
      logic              clear_m;
      logic              test;
      logic [BIT_W-1:0]  bit_idx;
      logic              load_zero_result;
      logic              load_score_result;
   } dp_cmd_type;

   typedef struct packed {
      logic norm_zero;
      logic pass;
   } dp_status_type;

endpackage

// ===== src/csu_datapath.sv =====
module csu_datapath import csu_pkg::*; #(
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a_element,
   input  logic signed [ELEMENT_WIDTH-1:0] req_b_element,
   input  dp_cmd_type                      cmd,
   output dp_status_type                   status,
   output logic signed [SCORE_W-1:0]       rsp_score,
   output logic                            rsp_zero_norm
);

   localparam int EPROD_W = 2 * ELEMENT_WIDTH;

   function automatic logic [LIMB_W-1:0] acc_limb(input logic [ACC_W-1:0] v,
                                                  input logic            hi);
      logic [LIMB_W-1:0] r;
      if (hi) begin
         r = LIMB_W'(v[ACC_W-1:LIMB_W]);
      end else begin
         r = v[LIMB_W-1:0];
      end
      return r;
   endfunction

   // element products, registered ahead of the sums
   logic signed [EPROD_W-1:0] ab_ff, aa_ff, bb_ff;
   logic                      pend_ff;

   logic [ACC_W-1:0] dot_ff, na_ff, nb_ff;
   logic [ACC_W-1:0] mag_ff;
   logic             sign_ff;

   logic [LIMB_W-1:0] op_x, op_y;
   logic [PROD_W-1:0] prod_ff;
   logic [WIDE_W-1:0] acc_ff, acc_in, prod_shifted;
   logic [DEN_W-1:0]  den_ff;
   logic [WIDE_W-1:0] rhs_ff;
   logic [LIMB_W-1:0] k_ff;

   logic [MAG_W-1:0]  m_ff, cand;
   logic [MAG_W:0]    odd_wide;
   logic [MAG_W-1:0]  odd;
   logic              pass;

   logic [SCORE_W-1:0] score_ff;
   logic               zero_norm_ff;

   always_ff @(posedge clock) begin
      ab_ff <= req_a_element * req_b_element;
      aa_ff <= req_a_element * req_a_element;
      bb_ff <= req_b_element * req_b_element;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.take_item;
      end
   end

   // sums wrap modulo 2^48
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (pend_ff) begin
         dot_ff <= dot_ff + ACC_W'(ab_ff);
         na_ff  <= na_ff + ACC_W'(aa_ff);
         nb_ff  <= nb_ff + ACC_W'(bb_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mag) begin
         sign_ff <= dot_ff[ACC_W-1];
         mag_ff  <= dot_ff[ACC_W-1] ? (ACC_W'(0) - dot_ff) : dot_ff;
      end
   end

   assign cand     = m_ff | (MAG_W'(1) << cmd.bit_idx);
   assign odd_wide = {cand, 1'b0} - (MAG_W+1)'(1);
   assign odd      = odd_wide[MAG_W-1:0];

   // shared 32x32 multiplier
   always_comb begin
      op_x = '0;
      op_y = '0;
      case (cmd.mul_sel)
         MUL_DEN: begin
            op_x = acc_limb(na_ff, cmd.step[1]);
            op_y = acc_limb(nb_ff, cmd.step[0]);
         end
         MUL_DSQ: begin
            op_x = acc_limb(mag_ff, cmd.step[1]);
            op_y = acc_limb(mag_ff, cmd.step[0]);
         end
         MUL_ODD: begin
            op_x = LIMB_W'(odd);
            op_y = LIMB_W'(odd);
         end
         MUL_LHS: begin
            case (cmd.step)
               2'd0:    op_x = den_ff[LIMB_W-1:0];
               2'd1:    op_x = den_ff[2*LIMB_W-1:LIMB_W];
               2'd2:    op_x = den_ff[3*LIMB_W-1:2*LIMB_W];
               default: op_x = '0;
            endcase
            op_y = k_ff;
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_x) * PROD_W'(op_y);
   end

   always_comb begin
      case (cmd.shift)
         2'd0:    prod_shifted = WIDE_W'(prod_ff);
         2'd1:    prod_shifted = {32'd0, prod_ff, 32'd0};
         2'd2:    prod_shifted = {prod_ff, 64'd0};
         default: prod_shifted = {prod_ff[LIMB_W-1:0], 96'd0};
      endcase
      acc_in = acc_ff + prod_shifted;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_den) begin
         den_ff <= acc_ff[DEN_W-1:0];
      end
      if (cmd.load_rhs) begin
         rhs_ff <= {acc_ff[DEN_W-1:0], 32'd0};
      end
      if (cmd.load_k) begin
         k_ff <= prod_ff[LIMB_W-1:0];
      end
   end

   // den * (2m-1)^2 <= dot^2 * 2^32 keeps candidate m
   assign pass = (acc_ff <= rhs_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_m) begin
         m_ff <= '0;
      end else if (cmd.test && pass) begin
         m_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_zero_result) begin
         score_ff     <= '0;
         zero_norm_ff <= 1'b1;
      end else if (cmd.load_score_result) begin
         zero_norm_ff <= 1'b0;
         if (m_ff[MAG_W-1]) begin
            score_ff <= sign_ff ? SCORE_MIN : SCORE_MAX;
         end else begin
            score_ff <= sign_ff ? (SCORE_W'(0) - m_ff) : m_ff;
         end
      end
   end

   assign status.norm_zero = (na_ff == '0) || (nb_ff == '0);
   assign status.pass      = pass;

   assign rsp_score     = score_ff;
   assign rsp_zero_norm = zero_norm_ff;

endmodule

// ===== src/csu_controller.sv =====
module csu_controller import csu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_pair,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output logic          req_stall,
   output logic          rsp_valid,
   output dp_cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_DEN;
      cmd.step    = step_ff;
      cmd.bit_idx = bit_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_stall     = 1'b0;
            cmd.take_item = req_valid;
            if (req_valid && req_last_pair) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.norm_zero) begin
               cmd.load_zero_result = 1'b1;
               state_in             = ST_OUTPUT;
            end else begin
               cmd.load_mag  = 1'b1;
               cmd.clear_acc = 1'b1;
               step_in       = '0;
               state_in      = ST_DEN_MUL;
            end
         end
         ST_DEN_MUL: begin
            cmd.mul_sel = MUL_DEN;
            state_in    = ST_DEN_ADD;
         end
         ST_DEN_ADD: begin
            cmd.acc_add = 1'b1;
            cmd.shift   = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            if (step_ff == 2'd3) begin
               state_in = ST_DEN_STORE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_DEN_MUL;
            end
         end
         ST_DEN_STORE: begin
            cmd.load_den  = 1'b1;
            cmd.clear_acc = 1'b1;
            step_in       = '0;
            state_in      = ST_DSQ_MUL;
         end
         ST_DSQ_MUL: begin
            cmd.mul_sel = MUL_DSQ;
            state_in    = ST_DSQ_ADD;
         end
         ST_DSQ_ADD: begin
            cmd.acc_add = 1'b1;
            cmd.shift   = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            if (step_ff == 2'd3) begin
               state_in = ST_DSQ_STORE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_DSQ_MUL;
            end
         end
         ST_DSQ_STORE: begin
            cmd.load_rhs = 1'b1;
            cmd.clear_m  = 1'b1;
            bit_in       = TOP_BIT;
            state_in     = ST_ODD_MUL;
         end
         ST_ODD_MUL: begin
            cmd.mul_sel = MUL_ODD;
            state_in    = ST_ODD_STORE;
         end
         ST_ODD_STORE: begin
            cmd.load_k    = 1'b1;
            cmd.clear_acc = 1'b1;
            step_in       = '0;
            state_in      = ST_LHS_MUL;
         end
         ST_LHS_MUL: begin
            cmd.mul_sel = MUL_LHS;
            state_in    = ST_LHS_ADD;
         end
         ST_LHS_ADD: begin
            cmd.acc_add = 1'b1;
            cmd.shift   = step_ff;
            if (step_ff == 2'd2) begin
               state_in = ST_COMPARE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_LHS_MUL;
            end
         end
         ST_COMPARE: begin
            cmd.test = 1'b1;
            // full-scale magnitude ends the search at once
            if ((bit_ff == TOP_BIT && status.pass) || bit_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_ODD_MUL;
            end
         end
         ST_FINISH: begin
            cmd.load_score_result = 1'b1;
            state_in              = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.clear_sums = 1'b1;
               state_in       = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

// ===== src/cosine_similarity_unit.sv =====
// Streaming cosine similarity. Each input item is one element pair of two
// equal-length vectors in signed Q1.15 (sign-extended from ELEMENT_WIDTH bits)
// plus a last-pair mark. While a vector streams in, one pair is taken every
// cycle and folded into three 48-bit wrapping sums: dot, norm_a and norm_b.
// The pair marked last produces one result item: score = dot / sqrt(na * nb)
// in Q1.15, rounded to nearest with halves away from zero and saturated to
// [-32768, 32767], with zero_norm = 0; if either norm is zero, score is 0 and
// zero_norm is 1. The sums then clear for the next vector. Input is stalled
// from the cycle after the last pair until the result item is taken. After
// the last pair, a zero norm skips the search; otherwise the result is found
// by a 16-step magnitude search that tests den * (2m-1)^2 <= dot^2 * 2^32
// exactly on one shared 32x32 multiplier, after forming the 96-bit
// denominator and 95-bit squared dot. The search ends early when the
// magnitude saturates on the first step. The multiplier is the pacing
// resource.
module cosine_similarity_unit import csu_pkg::*; #(
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel: one element pair per item
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [ELEMENT_WIDTH-1:0] req_a_element,
   input  logic signed [ELEMENT_WIDTH-1:0] req_b_element,
   input  logic                            req_last_pair,
   // response channel: one score per vector pair
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SCORE_W-1:0]       rsp_score,
   output logic                            rsp_zero_norm
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: accept window, search loop, result handshake
   csu_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_pair (req_last_pair),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   // sums, shared multiplier, wide accumulator and result register
   csu_datapath #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_a_element (req_a_element),
      .req_b_element (req_b_element),
      .cmd           (cmd),
      .status        (status),
      .rsp_score     (rsp_score),
      .rsp_zero_norm (rsp_zero_norm)
   );

`ifndef SYNTH
   // a zero norm always reports a zero score
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (rsp_score == '0))
      else $error("zero_norm result with nonzero score");

   // no new pair is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("pair accepted while result pending");

   // the last pair closes the accept window
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_pair) |=> (req_stall && !rsp_valid))
      else $error("accept window still open after last pair");

   // once the result is taken the next vector may stream in
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (!req_stall && !rsp_valid))
      else $error("block not ready after result taken");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for cosine_similarity_unit.
// A queue of element pairs is filled up front (directed vectors, then random
// vectors). A clocked driver feeds it to the request channel with random gaps.
// A clocked monitor stalls the response channel at random and checks each
// score against a cycle-free predictor that folds every accepted pair.
module tb_top import csu_pkg::*; ();

   localparam int EW          = 16;       // element width of the instance
   localparam int RAND_PAIRS  = 680;
   localparam int IDLE_LIMIT  = 2000;     // cycles with no handshake at all
   localparam int DRAIN_WAIT  = 200;      // exceeds the worst result latency
   localparam int SHOWN_ERRS  = 10;

   // shape of a random vector: how b relates to a
   typedef enum int {
      VK_INDEPENDENT,
      VK_SAME,
      VK_NEGATED,
      VK_NEAR,
      VK_ZERO_B
   } vec_kind_type;

   // value range of random elements
   typedef enum int {
      EK_ANY,
      EK_EXTREME,
      EK_SMALL
   } elem_kind_type;

   typedef struct {
      logic signed [EW-1:0] a;
      logic signed [EW-1:0] b;
      logic                 last;
      int unsigned          gap;      // idle cycles before this item
   } pair_type;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic               zero_norm;
   } score_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [EW-1:0]      req_a_element = '0;
   logic signed [EW-1:0]      req_b_element = '0;
   logic                      req_last_pair = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [SCORE_W-1:0] rsp_score;
   logic                      rsp_zero_norm;

   // stimulus and expectations
   pair_type  pair_q[$];
   score_type pending_scores[$];

   // predictor copy of the block's sums
   logic [ACC_W-1:0] dot_acc = '0;
   logic [ACC_W-1:0] na_acc  = '0;
   logic [ACC_W-1:0] nb_acc  = '0;

   // driver state
   pair_type    cur_pair;
   logic        pair_loaded = 1'b0;
   int unsigned gap_left = 0;

   // monitor state
   int unsigned stall_left = 0;
   logic        rsp_quiet = 1'b0;

   // bookkeeping
   int unsigned errors = 0;
   int unsigned pairs_taken = 0;
   int unsigned scores_seen = 0;
   int unsigned zero_norm_seen = 0;
   int unsigned saturated_seen = 0;
   int unsigned vectors_queued = 0;
   int unsigned idle_cycles = 0;

   cosine_similarity_unit #(
      .ELEMENT_WIDTH(EW)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_element (req_a_element),
      .req_b_element (req_b_element),
      .req_last_pair (req_last_pair),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_score     (rsp_score),
      .rsp_zero_norm (rsp_zero_norm)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Q1.15 cosine from the wrapped sums. The magnitude is the largest m in
   // [0, 32768] with den * (2m-1)^2 <= dot^2 * 2^32, i.e. round to nearest
   // with halves away from zero. All terms fit in 128 bits unsigned.
   function automatic logic [SCORE_W-1:0] cosine_q15(logic [ACC_W-1:0] dot,
                                                     logic [ACC_W-1:0] na,
                                                     logic [ACC_W-1:0] nb);
      logic [ACC_W-1:0] mag;
      logic [127:0]     den;
      logic [127:0]     rhs;
      logic [127:0]     lhs;
      logic [31:0]      odd;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      logic             neg;
      neg = dot[ACC_W-1];
      mag = neg ? -dot : dot;    // -2^47 stays 2^47 as unsigned
      den = 128'(na) * 128'(nb);
      rhs = (128'(mag) * 128'(mag)) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         lhs = den * (128'(odd) * 128'(odd));
         if (lhs <= rhs) lo = mid;
         else            hi = mid - 1;
      end
      if (lo == 32768) return neg ? SCORE_MIN : SCORE_MAX;
      return neg ? -lo[SCORE_W-1:0] : lo[SCORE_W-1:0];
   endfunction

   // fold one accepted pair into the sums; a last pair yields one score
   task automatic fold_pair(pair_type p);
      logic signed [31:0] ab;
      logic signed [31:0] aa;
      logic signed [31:0] bb;
      score_type          s;
      ab = p.a * p.b;
      aa = p.a * p.a;
      bb = p.b * p.b;
      dot_acc = dot_acc + {{(ACC_W-32){ab[31]}}, ab};
      na_acc  = na_acc  + {{(ACC_W-32){1'b0}}, aa};
      nb_acc  = nb_acc  + {{(ACC_W-32){1'b0}}, bb};
      pairs_taken++;
      if (p.last) begin
         if (na_acc == '0 || nb_acc == '0) begin
            s.score     = '0;
            s.zero_norm = 1'b1;
         end else begin
            s.score     = cosine_q15(dot_acc, na_acc, nb_acc);
            s.zero_norm = 1'b0;
         end
         pending_scores = {pending_scores, s};
         dot_acc = '0;
         na_acc  = '0;
         nb_acc  = '0;
      end
   endtask

   task automatic add_pair(int a, int b, bit last, int unsigned gap);
      pair_type p;
      p.a    = a[EW-1:0];
      p.b    = b[EW-1:0];
      p.last = last;
      p.gap  = gap;
      pair_q = {pair_q, p};
      if (last) vectors_queued++;
   endtask

   function automatic int pick_element(elem_kind_type kind);
      int extremes[5] = '{-32768, -1, 0, 1, 32767};
      case (kind)
         EK_EXTREME: return extremes[$urandom_range(0, 4)];
         EK_SMALL:   return $urandom_range(0, 16) - 8;
         default:    return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   // Driver: one nonblocking write per signal per edge. A fresh item is
   // loaded only after the current one is taken, so a stalled payload holds still.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         pair_loaded = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_pair(cur_pair);
            pair_loaded = 1'b0;
         end
         if (!pair_loaded && pair_q.size() > 0) begin
            cur_pair    = pair_q.pop_front();
            pair_loaded = 1'b1;
            gap_left    = cur_pair.gap;
         end
         if (pair_loaded && gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= pair_loaded;
         end
         req_a_element <= cur_pair.a;
         req_b_element <= cur_pair.b;
         req_last_pair <= cur_pair.last;
      end
   end

   // Monitor: after each taken score a new stall count is drawn; it runs
   // down only while a score is offered, so the stall lands on the result.
   // Roughly one result in three is taken with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            scores_seen++;
            if (rsp_zero_norm) zero_norm_seen++;
            if (rsp_score == SCORE_MAX || rsp_score == SCORE_MIN) saturated_seen++;
            if (pending_scores.size() == 0) begin
               errors++;
               if (errors <= SHOWN_ERRS)
                  $display("ERROR: unexpected score %0d zero_norm %0b",
                           rsp_score, rsp_zero_norm);
            end else begin
               score_type want;
               want = pending_scores.pop_front();
               if (rsp_score !== want.score || rsp_zero_norm !== want.zero_norm) begin
                  errors++;
                  if (errors <= SHOWN_ERRS)
                     $display("ERROR: score #%0d: expected %0d/%0b, got %0d/%0b",
                              scores_seen, $signed(want.score), want.zero_norm,
                              rsp_score, rsp_zero_norm);
               end
            end
            rsp_quiet  = ($urandom_range(0, 3) == 0);
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 9);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // Watchdog: any handshake resets the count.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int            len;
      int            a;
      int            b;
      int unsigned   random_pairs;
      bit            burst;
      vec_kind_type  vkind;
      elem_kind_type ekind;

      // --- directed vectors ---
      add_pair( 32767,  32767, 1, 0);  // +1 saturates to 32767
      add_pair(-32768,  32767, 1, 3);  // -1 gives -32768
      add_pair(-32768, -32768, 1, 0);  // both most negative: +1
      add_pair(-1, 1, 1, 1);           // smallest magnitudes, opposite
      add_pair(0, 5, 1, 0);            // zero norm on a
      add_pair(7, 0, 1, 0);            // zero norm on b
      add_pair(0, 0, 1, 2);            // both zero
      add_pair(1, 0, 0, 0);            // orthogonal: dot 0, norms nonzero
      add_pair(0, 1, 1, 0);
      add_pair(3, 4, 0, 0);            // 24/25
      add_pair(4, 3, 1, 5);
      add_pair(1, 1, 0, 0);            // 1/sqrt(2)
      add_pair(1, 0, 1, 0);
      add_pair(16'sh5555, -21846, 0, 9);  // alternating bit patterns
      add_pair(-21846, 16'sh5555, 0, 0);
      add_pair(32767, -32768, 0, 0);
      add_pair(-32768, -32768, 1, 0);
      add_pair(0, 0, 0, 0);            // zero pairs mixed into a real vector
      add_pair(100, -200, 0, 4);
      add_pair(0, 0, 1, 0);

      // --- random vectors: mostly short, a few longer ---
      random_pairs = 0;
      while (random_pairs < RAND_PAIRS) begin
         len   = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
         vkind = vec_kind_type'($urandom_range(VK_INDEPENDENT, VK_ZERO_B));
         ekind = elem_kind_type'($urandom_range(EK_ANY, EK_SMALL));
         burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            a = pick_element(ekind);
            case (vkind)
               VK_SAME:    b = a;
               VK_NEGATED: b = -a;
               VK_NEAR:    b = a + $urandom_range(0, 64) - 32;
               VK_ZERO_B:  b = 0;
               default:    b = pick_element(ekind);
            endcase
            add_pair(a, b, i == len - 1, burst ? 0 : $urandom_range(0, 9));
         end
         random_pairs += len;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, every score back, then a latency's worth more
      do @(negedge clock);
      while (pair_q.size() > 0 || pair_loaded || pending_scores.size() > 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d vectors, %0d element pairs, directed and random",
               vectors_queued, pairs_taken);
      $display("scores checked %0d: %0d zero-norm, %0d saturated, %0d errors",
               scores_seen, zero_norm_seen, saturated_seen, errors);
      if (errors == 0 && pending_scores.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/csu_pkg.sv
src/csu_datapath.sv
src/csu_controller.sv
src/cosine_similarity_unit.sv
tb/sv/tb_top.sv
